FILE: rtl/grid_maze_router_min_bends_core_macros.svh
// Assertion macros for the grid maze router.
`ifndef GRID_MAZE_ROUTER_MIN_BENDS_CORE_MACROS_SVH
`define GRID_MAZE_ROUTER_MIN_BENDS_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define GMR_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, off during reset
`define GMR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication, checked during reset too
`define GMR_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/gmr_pkg.sv
// Shared types and constants of the grid maze router.
package gmr_pkg;
   localparam int GRID_SIZE   = 64;
   localparam int COORD_W     = $clog2(GRID_SIZE);
   localparam int CELL_W      = 2 * COORD_W;
   localparam int CELL_COUNT  = GRID_SIZE * GRID_SIZE;
   localparam int STATE_W     = CELL_W + 2;
   localparam int STATE_COUNT = CELL_COUNT * 4;
   localparam int VALUE_W     = 10;
   localparam int LEN_W       = 12;
   localparam int CSR_INDEX_W = 1;

   localparam logic [VALUE_W-1:0] CELL_FREE = '0;

   localparam logic [1:0] DIR_XM = 2'd0;
   localparam logic [1:0] DIR_XP = 2'd1;
   localparam logic [1:0] DIR_YM = 2'd2;
   localparam logic [1:0] DIR_YP = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT = 1'd1;

   typedef enum logic [1:0] {
      CMD_WRITE  = 2'd0,
      CMD_READ   = 2'd1,
      CMD_ROUTE  = 2'd2,
      CMD_UNUSED = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_PATH  = 2'd1,
      ST_NOT_FREE = 2'd2,
      ST_RANGE    = 2'd3
   } status_type;

   typedef struct packed {
      logic [LEN_W-1:0] distance;
      logic [LEN_W-1:0] bend;
      logic [1:0]       prev;
   } search_entry_type;
endpackage

FILE: rtl/gmr_if.sv
// Channel interfaces of the grid maze router.
interface gmr_req_if import gmr_pkg::*;;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic [COORD_W-1:0] x_a;
   logic [COORD_W-1:0] y_a;
   logic [COORD_W-1:0] x_b;
   logic [COORD_W-1:0] y_b;
   logic [VALUE_W-1:0] cell_value;
   logic [VALUE_W-1:0] net_id;
   modport source (output valid, command, x_a, y_a, x_b, y_b, cell_value, net_id,
                   input ready);
   modport sink (input valid, command, x_a, y_a, x_b, y_b, cell_value, net_id,
                 output ready);
endinterface

interface gmr_rsp_if import gmr_pkg::*;;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [VALUE_W-1:0] cell_read;
   logic [LEN_W-1:0]   path_length;
   logic [LEN_W-1:0]   bend_count;
   modport source (output valid, status, cell_read, path_length, bend_count,
                   input ready);
   modport sink (input valid, status, cell_read, path_length, bend_count,
                 output ready);
endinterface

interface gmr_csr_if import gmr_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [COORD_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/gmr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gmr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

FILE: rtl/grid_maze_router_min_bends_core.sv
// Grid maze router: cell store plus shortest, then fewest-bend, wavefront search.
// Write and range rejects go straight to the response; read waits on the cell RAM.
// Not-free rejects follow the checks of A and B. Route: all 16384 search states are
// cleared, then each popped state is dequeued and loaded and each neighbor issued
// and, if in range, evaluated; then terminal scan, traceback. One item at a time.
// Reset: synchronous; a pass zeroes all 4096 cells of the store, no items taken.
module grid_maze_router_min_bends_core import gmr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   gmr_req_if.sink   req_ch,
   gmr_rsp_if.source rsp_ch,
   gmr_csr_if.sink   csr_ch
);
   typedef enum logic [4:0] {
      S_CLEAR_CELLS, S_IDLE, S_READ_WAIT, S_CHK_A, S_CHK_B, S_CLEAR_STATE,
      S_NB_ISSUE, S_NB_EVAL, S_POP, S_POP_WAIT, S_POP_LOAD, S_TERM_ISSUE,
      S_TERM_EVAL, S_TERM_DONE, S_MARK_B, S_TRACE_ISSUE, S_TRACE_WRITE, S_RESP
   } fsm_type;

   fsm_type state_ff, state_in;
   logic [STATE_W-1:0] clr_ff, clr_in;
   logic [COORD_W-1:0] xa_ff, xa_in, ya_ff, ya_in, xb_ff, xb_in, yb_ff, yb_in;
   logic [COORD_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [VALUE_W-1:0] net_ff, net_in;
   logic               a_free_ff, a_free_in;
   logic [CELL_W-1:0]  cur_cell_ff, cur_cell_in, pc_ff, pc_in;
   logic [1:0]         cur_dir_ff, cur_dir_in, dir_ff, dir_in;
   logic [LEN_W-1:0]   cur_dist_ff, cur_dist_in, cur_bend_ff, cur_bend_in;
   logic               seed_ff, seed_in;
   logic [STATE_W:0]   head_ff, head_in, tail_ff, tail_in;
   logic               best_valid_ff, best_valid_in;
   logic [LEN_W-1:0]   best_dist_ff, best_dist_in, best_bend_ff, best_bend_in;
   logic [1:0]         best_dir_ff, best_dir_in;
   logic [LEN_W-1:0]   k_ff, k_in;
   status_type         res_status_ff, res_status_in;
   logic [VALUE_W-1:0] res_read_ff, res_read_in;
   logic [LEN_W-1:0]   res_len_ff, res_len_in, res_bend_ff, res_bend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0] rsp_read_ff, rsp_read_in;
   logic [LEN_W-1:0]   rsp_len_ff, rsp_len_in, rsp_bend_ff, rsp_bend_in;

   logic                   cell_we;
   logic [CELL_W-1:0]      cell_waddr, cell_raddr;
   logic [VALUE_W-1:0]     cell_wdata, cell_rdata;
   logic                   st_we;
   logic [STATE_W-1:0]     st_waddr, st_raddr;
   search_entry_type       st_wdata, st_rdata;
   logic                   q_we;
   logic [STATE_W-1:0]     q_waddr, q_raddr, q_wdata, q_rdata;

   logic [CELL_W-1:0]  cell_a, cell_b, nb_cell;
   logic [COORD_W:0]   nx, ny, px, py;
   logic               nb_ok, trace_ok;
   logic [LEN_W-1:0]   nb_bend, next_dist;
   logic [1:0]         nb_prev;
   logic               better;

   gmr_ram #(.WIDTH(VALUE_W), .DEPTH(CELL_COUNT)) u_cell_ram (
      .clock(clock), .we(cell_we), .waddr(cell_waddr), .wdata(cell_wdata),
      .raddr(cell_raddr), .rdata(cell_rdata));

   gmr_ram #(.WIDTH($bits(search_entry_type)), .DEPTH(STATE_COUNT)) u_state_ram (
      .clock(clock), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
      .raddr(st_raddr), .rdata(st_rdata));

   gmr_ram #(.WIDTH(STATE_W), .DEPTH(STATE_COUNT)) u_queue_ram (
      .clock(clock), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
      .raddr(q_raddr), .rdata(q_rdata));

   assign cell_a = {ya_ff, xa_ff};
   assign cell_b = {yb_ff, xb_ff};
   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.cell_read = rsp_read_ff;
   assign rsp_ch.path_length = rsp_len_ff;
   assign rsp_ch.bend_count = rsp_bend_ff;

   // neighbor of the current cell in direction dir_ff
   always_comb begin
      nx = {1'b0, cur_cell_ff[COORD_W-1:0]};
      ny = {1'b0, cur_cell_ff[CELL_W-1:COORD_W]};
      case (dir_ff)
         DIR_XM:  nx = nx - 1'b1;
         DIR_XP:  nx = nx + 1'b1;
         DIR_YM:  ny = ny - 1'b1;
         default: ny = ny + 1'b1;
      endcase
      nb_ok = (nx != '0) && (ny != '0) && (nx <= {1'b0, width_ff}) &&
              (ny <= {1'b0, height_ff});
      nb_cell = {ny[COORD_W-1:0], nx[COORD_W-1:0]};
      nb_bend = seed_ff ? '0 : cur_bend_ff + ((dir_ff != cur_dir_ff) ? 1'b1 : 1'b0);
      nb_prev = seed_ff ? dir_ff : cur_dir_ff;
      next_dist = cur_dist_ff + 1'b1;
   end

   // predecessor of the current cell against arrival direction cur_dir_ff
   always_comb begin
      px = {1'b0, cur_cell_ff[COORD_W-1:0]};
      py = {1'b0, cur_cell_ff[CELL_W-1:COORD_W]};
      case (cur_dir_ff)
         DIR_XM:  px = px + 1'b1;
         DIR_XP:  px = px - 1'b1;
         DIR_YM:  py = py + 1'b1;
         default: py = py - 1'b1;
      endcase
      trace_ok = !px[COORD_W] && !py[COORD_W];
   end

   assign better = (st_rdata.distance != '0) &&
                   (!best_valid_ff || (st_rdata.distance < best_dist_ff) ||
                    ((st_rdata.distance == best_dist_ff) && (st_rdata.bend < best_bend_ff)));

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      xa_in = xa_ff; ya_in = ya_ff; xb_in = xb_ff; yb_in = yb_ff;
      width_in = width_ff; height_in = height_ff;
      net_in = net_ff;
      a_free_in = a_free_ff;
      cur_cell_in = cur_cell_ff; cur_dir_in = cur_dir_ff;
      cur_dist_in = cur_dist_ff; cur_bend_in = cur_bend_ff;
      seed_in = seed_ff; dir_in = dir_ff; pc_in = pc_ff;
      head_in = head_ff; tail_in = tail_ff;
      best_valid_in = best_valid_ff; best_dist_in = best_dist_ff;
      best_bend_in = best_bend_ff; best_dir_in = best_dir_ff;
      k_in = k_ff;
      res_status_in = res_status_ff; res_read_in = res_read_ff;
      res_len_in = res_len_ff; res_bend_in = res_bend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff; rsp_read_in = rsp_read_ff;
      rsp_len_in = rsp_len_ff; rsp_bend_in = rsp_bend_ff;
      cell_we = 1'b0; cell_waddr = cell_a; cell_wdata = net_ff;
      cell_raddr = cell_a;
      st_we = 1'b0; st_waddr = clr_ff; st_wdata = '0;
      st_raddr = {nb_cell, dir_ff};
      q_we = 1'b0; q_waddr = tail_ff[STATE_W-1:0]; q_wdata = {nb_cell, dir_ff};
      q_raddr = head_ff[STATE_W-1:0];

      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_WIDTH:  width_in = csr_ch.data;
            CSR_HEIGHT: height_in = csr_ch.data;
            default: ;
         endcase
      end

      case (state_ff)
         S_CLEAR_CELLS: begin
            cell_we = 1'b1;
            cell_waddr = clr_ff[CELL_W-1:0];
            cell_wdata = CELL_FREE;
            clr_in = clr_ff + 1'b1;
            if (clr_ff[CELL_W-1:0] == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               xa_in = req_ch.x_a; ya_in = req_ch.y_a;
               xb_in = req_ch.x_b; yb_in = req_ch.y_b;
               net_in = req_ch.net_id;
               res_status_in = ST_OK; res_read_in = '0;
               res_len_in = '0; res_bend_in = '0;
               state_in = S_RESP;
               case (command_type'(req_ch.command))
                  CMD_WRITE: begin
                     cell_we = 1'b1;
                     cell_waddr = {req_ch.y_a, req_ch.x_a};
                     cell_wdata = req_ch.cell_value;
                  end
                  CMD_READ: begin
                     cell_raddr = {req_ch.y_a, req_ch.x_a};
                     state_in = S_READ_WAIT;
                  end
                  CMD_ROUTE: begin
                     if ((req_ch.x_a == '0) || (req_ch.y_a == '0) ||
                         (req_ch.x_b == '0) || (req_ch.y_b == '0) ||
                         (req_ch.x_a > width_ff) || (req_ch.x_b > width_ff) ||
                         (req_ch.y_a > height_ff) || (req_ch.y_b > height_ff)) begin
                        res_status_in = ST_RANGE;
                     end else begin
                        cell_raddr = {req_ch.y_a, req_ch.x_a};
                        state_in = S_CHK_A;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_READ_WAIT: begin
            res_read_in = cell_rdata;
            state_in = S_RESP;
         end
         S_CHK_A: begin
            a_free_in = (cell_rdata == CELL_FREE);
            cell_raddr = cell_b;
            state_in = S_CHK_B;
         end
         S_CHK_B: begin
            if (!a_free_ff || (cell_rdata != CELL_FREE)) begin
               res_status_in = ST_NOT_FREE;
               state_in = S_RESP;
            end else if (cell_a == cell_b) begin
               cell_we = 1'b1;
               state_in = S_RESP;
            end else begin
               clr_in = '0;
               state_in = S_CLEAR_STATE;
            end
         end
         S_CLEAR_STATE: begin
            st_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               cur_cell_in = cell_a; cur_dir_in = DIR_XM;
               cur_dist_in = '0; cur_bend_in = '0;
               seed_in = 1'b1; dir_in = DIR_XM;
               head_in = '0; tail_in = '0;
               state_in = S_NB_ISSUE;
            end
         end
         S_NB_ISSUE: begin
            cell_raddr = nb_cell;
            if (nb_ok) begin
               state_in = S_NB_EVAL;
            end else if (dir_ff == DIR_YP) begin
               state_in = S_POP;
            end else begin
               dir_in = dir_ff + 1'b1;
            end
         end
         S_NB_EVAL: begin
            st_waddr = {nb_cell, dir_ff};
            if (cell_rdata == CELL_FREE) begin
               if (st_rdata.distance == '0) begin
                  st_we = 1'b1;
                  st_wdata = '{distance: next_dist, bend: nb_bend, prev: nb_prev};
                  if (!tail_ff[STATE_W]) begin
                     q_we = 1'b1;
                     tail_in = tail_ff + 1'b1;
                  end
               end else if ((st_rdata.distance == next_dist) &&
                            ((nb_bend < st_rdata.bend) ||
                             ((nb_bend == st_rdata.bend) && (nb_prev < st_rdata.prev)))) begin
                  st_we = 1'b1;
                  st_wdata = '{distance: st_rdata.distance, bend: nb_bend, prev: nb_prev};
               end
            end
            if (dir_ff == DIR_YP) begin
               state_in = S_POP;
            end else begin
               dir_in = dir_ff + 1'b1;
               state_in = S_NB_ISSUE;
            end
         end
         S_POP: begin
            if (head_ff == tail_ff) begin
               dir_in = DIR_XM;
               best_valid_in = 1'b0;
               state_in = S_TERM_ISSUE;
            end else begin
               head_in = head_ff + 1'b1;
               state_in = S_POP_WAIT;
            end
         end
         S_POP_WAIT: begin
            cur_cell_in = q_rdata[STATE_W-1:2];
            cur_dir_in = q_rdata[1:0];
            st_raddr = q_rdata;
            state_in = (q_rdata[STATE_W-1:2] == cell_b) ? S_POP : S_POP_LOAD;
         end
         S_POP_LOAD: begin
            cur_dist_in = st_rdata.distance;
            cur_bend_in = st_rdata.bend;
            seed_in = 1'b0;
            dir_in = DIR_XM;
            state_in = S_NB_ISSUE;
         end
         S_TERM_ISSUE: begin
            st_raddr = {cell_b, dir_ff};
            state_in = S_TERM_EVAL;
         end
         S_TERM_EVAL: begin
            if (better) begin
               best_valid_in = 1'b1;
               best_dist_in = st_rdata.distance;
               best_bend_in = st_rdata.bend;
               best_dir_in = dir_ff;
            end
            if (dir_ff == DIR_YP) begin
               state_in = S_TERM_DONE;
            end else begin
               dir_in = dir_ff + 1'b1;
               state_in = S_TERM_ISSUE;
            end
         end
         S_TERM_DONE: begin
            if (!best_valid_ff) begin
               res_status_in = ST_NO_PATH;
               state_in = S_RESP;
            end else begin
               res_len_in = best_dist_ff;
               res_bend_in = best_bend_ff;
               cell_we = 1'b1;
               state_in = S_MARK_B;
            end
         end
         S_MARK_B: begin
            cell_we = 1'b1;
            cell_waddr = cell_b;
            cur_cell_in = cell_b;
            cur_dir_in = best_dir_ff;
            k_in = best_dist_ff;
            state_in = S_TRACE_ISSUE;
         end
         S_TRACE_ISSUE: begin
            st_raddr = {cur_cell_ff, cur_dir_ff};
            pc_in = {py[COORD_W-1:0], px[COORD_W-1:0]};
            state_in = ((k_ff > 12'd1) && trace_ok) ? S_TRACE_WRITE : S_RESP;
         end
         S_TRACE_WRITE: begin
            cell_we = 1'b1;
            cell_waddr = pc_ff;
            cur_cell_in = pc_ff;
            cur_dir_in = st_rdata.prev;
            k_in = k_ff - 1'b1;
            state_in = S_TRACE_ISSUE;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_read_in = res_read_ff;
               rsp_len_in = res_len_ff;
               rsp_bend_in = res_bend_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR_CELLS;
         clr_ff <= '0;
         width_ff <= 6'd63;
         height_ff <= 6'd63;
         rsp_valid_ff <= 1'b0;
         head_ff <= '0;
         tail_ff <= '0;
         seed_ff <= 1'b0;
         best_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         width_ff <= width_in;
         height_ff <= height_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         seed_ff <= seed_in;
         best_valid_ff <= best_valid_in;
      end
      xa_ff <= xa_in; ya_ff <= ya_in; xb_ff <= xb_in; yb_ff <= yb_in;
      net_ff <= net_in;
      a_free_ff <= a_free_in;
      cur_cell_ff <= cur_cell_in; cur_dir_ff <= cur_dir_in;
      cur_dist_ff <= cur_dist_in; cur_bend_ff <= cur_bend_in;
      dir_ff <= dir_in; pc_ff <= pc_in;
      best_dist_ff <= best_dist_in; best_bend_ff <= best_bend_in;
      best_dir_ff <= best_dir_in;
      k_ff <= k_in;
      res_status_ff <= res_status_in; res_read_ff <= res_read_in;
      res_len_ff <= res_len_in; res_bend_ff <= res_bend_in;
      rsp_status_ff <= rsp_status_in; rsp_read_ff <= rsp_read_in;
      rsp_len_ff <= rsp_len_in; rsp_bend_ff <= rsp_bend_in;
   end
endmodule

FILE: rtl/gmr_checker.sv
// Port-level checker of the grid maze router and its bind.
`include "grid_maze_router_min_bends_core_macros.svh"

module gmr_checker import gmr_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_status,
   input logic [VALUE_W-1:0] rsp_cell_read,
   input logic [LEN_W-1:0]   rsp_path_length,
   input logic [LEN_W-1:0]   rsp_bend_count
);
   `GMR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `GMR_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready)
   `GMR_ASSERT_SAME(a_fail_empty, rsp_valid && (rsp_status != ST_OK), (rsp_cell_read == '0) && (rsp_path_length == '0) && (rsp_bend_count == '0))
   `GMR_ASSERT_NEXT_ALWAYS(a_reset_quiet, reset, !rsp_valid && !req_ready)
endmodule

bind grid_maze_router_min_bends_core gmr_checker u_gmr_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_ch.valid),
   .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .rsp_status(rsp_ch.status),
   .rsp_cell_read(rsp_ch.cell_read),
   .rsp_path_length(rsp_ch.path_length),
   .rsp_bend_count(rsp_ch.bend_count)
);
